// ===== rtl/core/pixel_priority_mux_defines.svh =====
// Assertion macros for the pixel priority mux.
// Used by the top level only; expects clk and rst in scope.
`ifndef PIXEL_PRIORITY_MUX_DEFINES_SVH
`define PIXEL_PRIORITY_MUX_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel_priority_mux: check failed");

// Next-cycle implication, disabled while in reset
`define PPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel_priority_mux: check failed");

`endif

// ===== rtl/core/ppm_pkg.sv =====
// Shared types, codes and tables for the pixel priority mux.
// No dependencies; imported by ppm_shade and pixel_priority_mux.
package ppm_pkg;

  // Item kinds carried on s_tuser
  typedef enum logic [1:0] {
    FUNC_PIXEL     = 2'd0,
    FUNC_PAL_WRITE = 2'd1,
    FUNC_CLEAR_HIT = 2'd2
  } func_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SHOW_BG   = 2'd0,
    CFG_SHOW_SPR  = 2'd1,
    CFG_EMPHASIS  = 2'd2,
    CFG_PAL_MASK  = 2'd3
  } cfg_index_t;

  localparam int unsigned PAL_DEPTH   = 32;
  localparam logic [5:0]  PAL_MASK_RST = 6'h3f;

  // Emphasis bit positions
  localparam int unsigned EMPH_RED   = 0;
  localparam int unsigned EMPH_GREEN = 1;
  localparam int unsigned EMPH_BLUE  = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Palette address with the backdrop mirrors folded down
  function automatic logic [4:0] pal_slot(input logic [4:0] addr);
    logic [4:0] a;
    a = addr;
    if ((a & 5'h13) == 5'h10) a = a & 5'h0f;
    return a;
  endfunction

  // floor(c * 3 / 4)
  function automatic logic [7:0] darken(input logic [7:0] c);
    logic [9:0] t;
    t = {2'b00, c} + {1'b0, c, 1'b0};
    return t[9:2];
  endfunction

  // Fixed RGB table, 0xRRGGBB
  function automatic logic [23:0] colour_lookup(input logic [5:0] idx);
    logic [23:0] c;
    unique case (idx)
      6'd0:  c = 24'h808080;  6'd1:  c = 24'h1E509D;  6'd2:  c = 24'h3C3CB9;
      6'd3:  c = 24'h5D2BB7;  6'd4:  c = 24'h792398;  6'd5:  c = 24'h882564;
      6'd6:  c = 24'h873129;  6'd7:  c = 24'h764400;  6'd8:  c = 24'h585800;
      6'd9:  c = 24'h376900;  6'd10: c = 24'h1B7100;  6'd11: c = 24'h0C6F30;
      6'd12: c = 24'h0D636B;  6'd13: c = 24'h000000;  6'd14: c = 24'h000000;
      6'd15: c = 24'h000000;  6'd16: c = 24'hBFBFBF;  6'd17: c = 24'h4779C6;
      6'd18: c = 24'h6464E2;  6'd19: c = 24'h8554E0;  6'd20: c = 24'hA24CC0;
      6'd21: c = 24'hB14E8C;  6'd22: c = 24'hB05A51;  6'd23: c = 24'h9E6D20;
      6'd24: c = 24'h818104;  6'd25: c = 24'h609206;  6'd26: c = 24'h449A25;
      6'd27: c = 24'h349859;  6'd28: c = 24'h368B94;  6'd29: c = 24'h3D3D3D;
      6'd30: c = 24'h000000;  6'd31: c = 24'h000000;  6'd32: c = 24'hFFFFFF;
      6'd33: c = 24'h8FC0FF;  6'd34: c = 24'hACACFF;  6'd35: c = 24'hCD9BFF;
      6'd36: c = 24'hE993FF;  6'd37: c = 24'hF895D4;  6'd38: c = 24'hF7A199;
      6'd39: c = 24'hE6B467;  6'd40: c = 24'hC9C84B;  6'd41: c = 24'hA7D94D;
      6'd42: c = 24'h8BE16D;  6'd43: c = 24'h7CDFA1;  6'd44: c = 24'h7DD3DB;
      6'd45: c = 24'h787878;  6'd46: c = 24'h000000;  6'd47: c = 24'h000000;
      6'd48: c = 24'hFFFFFF;  6'd49: c = 24'hBAEBFF;  6'd50: c = 24'hD7D7FF;
      6'd51: c = 24'hF8C7FF;  6'd52: c = 24'hFFBFFF;  6'd53: c = 24'hFFC1FF;
      6'd54: c = 24'hFFCDC4;  6'd55: c = 24'hFFE092;  6'd56: c = 24'hF4F477;
      6'd57: c = 24'hD3FF79;  6'd58: c = 24'hB7FF98;  6'd59: c = 24'hA7FFCC;
      6'd60: c = 24'hA8FEFF;  6'd61: c = 24'hC4C4C4;  6'd62: c = 24'h000000;
      6'd63: c = 24'h000000;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/ppm_shade.sv =====
// Colour stage: palette value -> masked ROM lookup -> emphasis darkening.
// Depends on ppm_pkg (rgb_t, colour_lookup, darken).
module ppm_shade import ppm_pkg::*; (
  input  logic [5:0] pal_value,
  input  logic [5:0] palette_mask,
  input  logic [2:0] emphasis,
  output rgb_t       rgb
);

  logic [23:0] rom_rgb;
  logic [7:0]  r0, g0, b0;
  logic [7:0]  r1, g1, b1;
  logic [7:0]  r2, g2, b2;

  // Table lookup
  assign rom_rgb = colour_lookup(pal_value & palette_mask);
  assign r0 = rom_rgb[23:16];
  assign g0 = rom_rgb[15:8];
  assign b0 = rom_rgb[7:0];

  // Emphasis in the same order as the bits: blue, green, red
  always_comb begin
    r1 = emphasis[EMPH_BLUE]  ? darken(r0) : r0;
    g1 = emphasis[EMPH_BLUE]  ? darken(g0) : g0;
    b1 = b0;
    r2 = emphasis[EMPH_GREEN] ? darken(r1) : r1;
    g2 = g1;
    b2 = emphasis[EMPH_GREEN] ? darken(b1) : b1;
    rgb.red   = r2;
    rgb.green = emphasis[EMPH_RED] ? darken(g2) : g2;
    rgb.blue  = emphasis[EMPH_RED] ? darken(b2) : b2;
  end

endmodule

// ===== rtl/core/pixel_priority_mux.sv =====
// Pixel priority mux top level: item register, palette store, result register.
// Depends on ppm_pkg, ppm_shade and pixel_priority_mux_defines.svh.
//
// Usage:
//   s_* carries one item per accepted beat; s_tuser holds the item kind
//   (pixel, palette write, clear sprite-zero hit). m_* returns exactly one
//   result per item: RGB (zero for non-pixel items) plus the sticky hit flag.
//   cfg_we/cfg_index/cfg_data write the show, emphasis and mask registers
//   and must only be used while the block is idle.
// Registers: the input register loads at accept, and the result register
//   loads from it. Throughput: one item per cycle while m_tready is high;
//   the palette read, ROM lookup and darkening all sit between those two registers.
// Palette writes take effect in item order, so a pixel right behind a
//   write sees the new value.
// Reset: clears the pipeline, the palette (all zero), the hit flag and
//   the config registers (palette mask to all ones).
// Stall: when m_tready is low the result holds and the input register
//   keeps taking one more item; after that s_tready drops.
`include "pixel_priority_mux_defines.svh"

module pixel_priority_mux import ppm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // bg_code[3:0], spr_code[8:4], spr_behind[9], spr_is_zero[10],
  // pixel_x[18:11], pal_addr[23:19], pal_data[29:24], zero[31:30]
  input  logic [31:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  // red[7:0], green[15:8], blue[23:16], hit_flag[24], zero[31:25]
  output logic [31:0] m_tdata,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] bg_code;
    logic [4:0] spr_code;
    logic       spr_behind;
    logic       spr_is_zero;
    logic [7:0] pixel_x;
    logic [4:0] pal_addr;
    logic [5:0] pal_data;
  } item_t;

  // Config registers
  logic       show_background;
  logic       show_sprites;
  logic [2:0] emphasis;
  logic [5:0] palette_mask;

  // Pipeline state
  logic       s1_valid;
  item_t      s1;
  logic       out_valid;
  rgb_t       out_rgb;
  logic       out_hit;
  logic       sprite_zero_hit;
  logic       sprite_zero_hit_next;
  logic [5:0] palette_ram [PAL_DEPTH];

  logic       advance;
  logic       s1_is_pixel;
  logic       spr_wins;
  logic [4:0] read_addr;
  logic [5:0] pal_value;
  rgb_t       shade_rgb;

  // Handshake
  assign advance  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_hit, out_rgb.blue, out_rgb.green, out_rgb.red};

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      show_background <= 1'b0;
      show_sprites    <= 1'b0;
      emphasis        <= 3'd0;
      palette_mask    <= PAL_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SHOW_BG:  show_background <= cfg_data[0];
        CFG_SHOW_SPR: show_sprites    <= cfg_data[0];
        CFG_EMPHASIS: emphasis        <= cfg_data[2:0];
        CFG_PAL_MASK: palette_mask    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1.func        <= s_tuser;
      s1.bg_code     <= s_tdata[3:0];
      s1.spr_code    <= s_tdata[8:4];
      s1.spr_behind  <= s_tdata[9];
      s1.spr_is_zero <= s_tdata[10];
      s1.pixel_x     <= s_tdata[18:11];
      s1.pal_addr    <= s_tdata[23:19];
      s1.pal_data    <= s_tdata[29:24];
    end
  end

  // Priority select and palette read
  assign s1_is_pixel = (func_t'(s1.func) == FUNC_PIXEL);
  assign spr_wins    = (s1.spr_code != 5'd0) && (!s1.spr_behind || s1.bg_code == 4'd0);

  always_comb begin
    priority if (spr_wins) begin
      read_addr = pal_slot(s1.spr_code);
    end else if (s1.bg_code != 4'd0) begin
      read_addr = pal_slot({1'b0, s1.bg_code});
    end else begin
      read_addr = 5'd0;
    end
  end

  assign pal_value = palette_ram[read_addr];

  ppm_shade u_shade (
    .pal_value    (pal_value),
    .palette_mask (palette_mask),
    .emphasis     (emphasis),
    .rgb          (shade_rgb)
  );

  // Sticky sprite-zero hit
  always_comb begin
    sprite_zero_hit_next = sprite_zero_hit;
    unique case (func_t'(s1.func))
      FUNC_PIXEL: begin
        if (s1.spr_is_zero && s1.spr_code != 5'd0 && s1.bg_code != 4'd0 &&
            show_background && show_sprites && s1.pixel_x != 8'hff)
          sprite_zero_hit_next = 1'b1;
      end
      FUNC_CLEAR_HIT: sprite_zero_hit_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_zero_hit <= 1'b0;
    end else if (advance) begin
      sprite_zero_hit <= sprite_zero_hit_next;
    end
  end

  // Palette store, written in item order
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAL_DEPTH; i++) palette_ram[i] <= 6'd0;
    end else if (advance && func_t'(s1.func) == FUNC_PAL_WRITE) begin
      palette_ram[pal_slot(s1.pal_addr)] <= s1.pal_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rgb <= s1_is_pixel ? shade_rgb : '0;
      out_hit <= sprite_zero_hit_next;
    end
  end

  // Checks
  `PPM_ASSERT_NEXT(a_clear_hit, advance && func_t'(s1.func) == FUNC_CLEAR_HIT, !out_hit && !sprite_zero_hit)
  `PPM_ASSERT_NEXT(a_nonpixel_black, advance && !s1_is_pixel, out_rgb == '0)
  `PPM_ASSERT_NEXT(a_hit_sticky, sprite_zero_hit && !(advance && func_t'(s1.func) == FUNC_CLEAR_HIT), sprite_zero_hit)
  `PPM_ASSERT_NOW(a_hold_full, s1_valid && out_valid && !m_tready, !s_tready)

endmodule
